>>> hw/rtl/fcca_pkg.sv
`timescale 1ns / 1ps

package fcca_pkg;

	// Table geometry.
	localparam int NUM_CLUSTERS = 128;
	localparam int CLUSTER_W    = $clog2(NUM_CLUSTERS);
	localparam int PTR_W        = CLUSTER_W + 1;
	localparam int COUNT_W      = 8;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;

	// Operation codes carried in the input transaction.
	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_SET_LEN = 2'd1,
		OP_FREE    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Status codes carried in the result transaction.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_FREE  = 2'd1,
		STAT_NOT_USED = 2'd2
	} status_t;

	// One table entry: in-use flag, end-of-chain flag and link to the next cluster.
	typedef struct packed {
		logic                 used;
		logic                 last;
		logic [CLUSTER_W-1:0] next;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_START_RD,
		S_START_CHK,
		S_SCAN,
		S_FINISH,
		S_WALK_RD,
		S_WALK_CHK,
		S_RESULT
	} state_t;

endpackage

>>> hw/rtl/fcca_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered read data.
module fcca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/fat_cluster_chain_allocator_top.sv
`timescale 1ns / 1ps

// Allocate: the scan reads one entry a cycle from cluster 0 up and takes the lowest free cluster.
// Set-length: checks the start cluster, then scans each entry at most once and links each free cluster to the tail.
// Free: walks the chain with a dependent read of each link; it ends at the last cluster or at a link to a free one.
// One operation at a time; the next transaction is taken while a result waits at the output.
// Reset clears the per-entry valid flags at once; an entry never written reads as free.
module fat_cluster_chain_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// s_axis_tdata: [6:0] start_cluster, [14:7] cluster_count, [15] zero.
	input  logic [15:0] s_axis_tdata,
	// s_axis_tuser: [1:0] operation.
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// m_axis_tdata: [6:0] cluster_index, [14:7] clusters_done, [15] zero.
	output logic [15:0] m_axis_tdata,
	// m_axis_tuser: [1:0] status.
	output logic [1:0]  m_axis_tuser
);

	localparam int CW = fcca_pkg::CLUSTER_W;
	localparam int PW = fcca_pkg::PTR_W;
	localparam int NW = fcca_pkg::COUNT_W;

	fcca_pkg::state_t  state_q, state_d;
	fcca_pkg::op_t     op_q;
	fcca_pkg::status_t res_status_q;
	logic [CW-1:0]     cur_q;
	logic [CW-1:0]     res_idx_q;
	logic [NW-1:0]     count_q;
	logic [NW-1:0]     want_q;
	logic [PW-1:0]     ptr_q;
	logic              chk_vld_q;
	logic [CW-1:0]     chk_addr_q;
	logic [fcca_pkg::NUM_CLUSTERS-1:0] valid_q;
	logic              valid_rd_q;

	logic                        ram_we;
	logic [CW-1:0]               ram_waddr;
	fcca_pkg::entry_t            ram_wdata;
	logic [CW-1:0]               ram_raddr;
	logic [fcca_pkg::ENTRY_W-1:0] ram_rdata;
	fcca_pkg::entry_t            rd_entry;

	logic s_fire;
	logic load_res;
	logic issue;
	logic found;
	logic exhausted;
	logic walk_go;
	logic link_done;

	logic [7:0] m_done_q;
	logic [6:0] m_idx_q;
	logic [1:0] m_status_q;
	logic       m_valid_q;

	fcca_ram #(
		.WIDTH(fcca_pkg::ENTRY_W),
		.DEPTH(fcca_pkg::NUM_CLUSTERS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// An entry never written since reset reads as free.
	assign rd_entry = valid_rd_q ? fcca_pkg::entry_t'(ram_rdata) : '0;

	// Scan and walk conditions.
	assign s_fire    = s_axis_tvalid && s_axis_tready;
	assign issue     = ptr_q < PW'(fcca_pkg::NUM_CLUSTERS);
	assign found     = chk_vld_q && !rd_entry.used;
	assign exhausted = !chk_vld_q && !issue;
	assign walk_go   = (count_q < NW'(fcca_pkg::NUM_CLUSTERS)) && rd_entry.used;
	assign link_done = (count_q + NW'(1)) == want_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fcca_pkg::S_IDLE: begin
				if (s_fire) begin
					unique case (fcca_pkg::op_t'(s_axis_tuser))
						fcca_pkg::OP_ALLOC:   state_d = fcca_pkg::S_SCAN;
						fcca_pkg::OP_SET_LEN: state_d = fcca_pkg::S_START_RD;
						fcca_pkg::OP_FREE:    state_d = fcca_pkg::S_WALK_RD;
						default:              state_d = fcca_pkg::S_RESULT;
					endcase
				end
			end
			fcca_pkg::S_START_RD: state_d = fcca_pkg::S_START_CHK;
			fcca_pkg::S_START_CHK: begin
				priority if (!rd_entry.used) begin
					state_d = fcca_pkg::S_RESULT;
				end else if (want_q == '0) begin
					state_d = fcca_pkg::S_FINISH;
				end else begin
					state_d = fcca_pkg::S_SCAN;
				end
			end
			fcca_pkg::S_SCAN: begin
				if (op_q == fcca_pkg::OP_ALLOC) begin
					if (found || exhausted) begin
						state_d = fcca_pkg::S_RESULT;
					end
				end else begin
					if ((found && link_done) || exhausted) begin
						state_d = fcca_pkg::S_FINISH;
					end
				end
			end
			fcca_pkg::S_FINISH: state_d = fcca_pkg::S_RESULT;
			fcca_pkg::S_WALK_RD: state_d = fcca_pkg::S_WALK_CHK;
			fcca_pkg::S_WALK_CHK: begin
				if (walk_go && !rd_entry.last) begin
					state_d = fcca_pkg::S_WALK_RD;
				end else begin
					state_d = fcca_pkg::S_RESULT;
				end
			end
			fcca_pkg::S_RESULT: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = fcca_pkg::S_IDLE;
				end
			end
			default: state_d = fcca_pkg::S_IDLE;
		endcase
	end

	// Memory control and handshake outputs.
	always_comb begin
		ram_we        = 1'b0;
		ram_waddr     = cur_q;
		ram_wdata     = '0;
		ram_raddr     = cur_q;
		s_axis_tready = 1'b0;
		load_res      = 1'b0;
		unique case (state_q)
			fcca_pkg::S_IDLE: s_axis_tready = 1'b1;
			fcca_pkg::S_SCAN: begin
				ram_raddr = ptr_q[CW-1:0];
				if (found) begin
					ram_we = 1'b1;
					if (op_q == fcca_pkg::OP_ALLOC) begin
						// The new cluster becomes a one-cluster chain.
						ram_waddr = chk_addr_q;
						ram_wdata = '{used: 1'b1, last: 1'b1, next: '0};
					end else begin
						// Link the current tail to the cluster just found.
						ram_waddr = cur_q;
						ram_wdata = '{used: 1'b1, last: 1'b0, next: chk_addr_q};
					end
				end
			end
			fcca_pkg::S_FINISH: begin
				ram_we    = 1'b1;
				ram_wdata = '{used: 1'b1, last: 1'b1, next: '0};
			end
			fcca_pkg::S_WALK_CHK: begin
				ram_we = walk_go;
			end
			fcca_pkg::S_RESULT: load_res = !m_valid_q || m_axis_tready;
			default: begin
			end
		endcase
	end

	// Per-entry valid flags and the flag of the entry being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			valid_rd_q <= valid_q[ram_raddr];
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	// Sequencer state and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fcca_pkg::S_IDLE;
			chk_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fcca_pkg::S_SCAN && !found) begin
				chk_vld_q <= issue;
			end else begin
				chk_vld_q <= 1'b0;
			end
		end
	end

	// Operation datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			fcca_pkg::S_IDLE: begin
				op_q         <= fcca_pkg::op_t'(s_axis_tuser);
				cur_q        <= s_axis_tdata[CW-1:0];
				want_q       <= (s_axis_tdata[14:7] == '0) ? '0 : s_axis_tdata[14:7] - NW'(1);
				count_q      <= '0;
				res_idx_q    <= '0;
				res_status_q <= fcca_pkg::STAT_OK;
				ptr_q        <= '0;
			end
			fcca_pkg::S_START_CHK: begin
				if (!rd_entry.used) begin
					res_status_q <= fcca_pkg::STAT_NOT_USED;
				end
			end
			fcca_pkg::S_SCAN: begin
				priority if (found) begin
					cur_q      <= chk_addr_q;
					res_idx_q  <= chk_addr_q;
					count_q    <= count_q + NW'(1);
					ptr_q      <= PW'(chk_addr_q) + PW'(1);
				end else if (exhausted) begin
					res_status_q <= fcca_pkg::STAT_NO_FREE;
				end else begin
					ptr_q      <= ptr_q + PW'(issue);
					chk_addr_q <= ptr_q[CW-1:0];
				end
			end
			fcca_pkg::S_FINISH: res_idx_q <= cur_q;
			fcca_pkg::S_WALK_CHK: begin
				priority if (walk_go) begin
					res_idx_q <= cur_q;
					count_q   <= count_q + NW'(1);
					cur_q     <= rd_entry.next;
				end else if (count_q == '0) begin
					res_status_q <= fcca_pkg::STAT_NOT_USED;
				end else begin
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: holds one result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_res) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			m_status_q <= res_status_q;
			m_idx_q    <= 7'(res_idx_q);
			m_done_q   <= 8'(count_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_done_q, m_idx_q};
	assign m_axis_tuser  = m_status_q;

endmodule
